[src/alcr_pkg.sv]
// alcr_pkg: shared types and constants of the line and circle rasterizer
// no dependencies
`timescale 1ns / 1ps
package alcr_pkg;
  localparam int DefMaxWidth  = 128;
  localparam int DefMaxHeight = 128;
  localparam int CoordW       = 14;
  localparam int PixW         = 24;

  localparam logic [1:0] KIND_LINE   = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] REG_WIDE = 2'd0;
  localparam logic [1:0] REG_HW   = 2'd1;
  localparam logic [1:0] REG_HH   = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       rd;
    logic       wide;
    logic [7:0] color;
  } frame_req_t;

  typedef struct packed {
    logic ready;
    logic rvalid;
  } frame_rsp_t;
endpackage

[src/alcr_frame.sv]
// alcr_frame: frame store with clearing sweep and saturating read-modify-write
// depends on alcr_pkg
`timescale 1ns / 1ps
module alcr_frame #(
  parameter int MaxWidth  = alcr_pkg::DefMaxWidth,
  parameter int MaxHeight = alcr_pkg::DefMaxHeight,
  localparam int Depth = MaxWidth * MaxHeight,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  alcr_pkg::frame_req_t     req_i,
  input  logic [AddrW-1:0]         addr_i,
  output alcr_pkg::frame_rsp_t     rsp_o,
  output logic [alcr_pkg::PixW-1:0] rdata_o
);
  import alcr_pkg::*;

  typedef enum logic [1:0] {FR_CLEAR, FR_IDLE, FR_RMW} fr_state_e;

  fr_state_e        state_q;
  logic [AddrW-1:0] cnt_q;
  logic [AddrW-1:0] addr_q;
  logic             rd_q;
  logic             wide_q;
  logic [7:0]       color_q;
  logic [PixW-1:0]  rdata_q;
  logic [PixW-1:0]  mem [Depth];

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [PixW-1:0]  wdata;
  logic [PixW-1:0]  sum_px;

  always_comb begin
    logic [8:0] s;
    sum_px = rdata_q;
    for (int c = 0; c < 3; c++) begin
      s = {1'b0, rdata_q[8*c +: 8]} + {1'b0, color_q};
      if (c == 0 || wide_q) begin
        sum_px[8*c +: 8] = s[8] ? 8'hFF : s[7:0];
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = sum_px;
    if (state_q == FR_CLEAR) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = '0;
    end else if (state_q == FR_RMW && !rd_q) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (state_q == FR_IDLE && req_i.valid) begin
      rdata_q <= mem[addr_i];
      addr_q  <= addr_i;
      rd_q    <= req_i.rd;
      wide_q  <= req_i.wide;
      color_q <= req_i.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_CLEAR;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        FR_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AddrW'(Depth - 1)) state_q <= FR_IDLE;
        end
        FR_IDLE: begin
          if (req_i.valid) state_q <= FR_RMW;
        end
        FR_RMW:  state_q <= FR_IDLE;
        default: state_q <= FR_IDLE;
      endcase
    end
  end

  assign rsp_o.ready  = (state_q == FR_IDLE);
  assign rsp_o.rvalid = (state_q == FR_RMW) && rd_q;
  assign rdata_o      = rdata_q;
endmodule

[src/additive_line_circle_rasterizer.sv]
// additive_line_circle_rasterizer: command sequencer for lines, circles and reads
// depends on alcr_pkg and alcr_frame
`timescale 1ns / 1ps
// channel  | dir | handshake
// command  | in  | start_i high while busy_o low
// result   | out | done_o strobe, one cycle
// config   | in  | apb write, psel & penable & pwrite & pready
// each plotted point in the window takes a memory read, then a write back, and a
// clipped point takes no memory access; a line plots n = max(|dx|,|dy|) points,
// a circle eight points per step, a read one memory read. after reset the frame store is
// cleared one pixel a cycle, all MaxWidth*MaxHeight pixels, with busy_o high.
// results cannot stall.
module additive_line_circle_rasterizer #(
  parameter int MaxWidth  = alcr_pkg::DefMaxWidth,
  parameter int MaxHeight = alcr_pkg::DefMaxHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         kind_i,
  input  logic signed [11:0] x_a_i,
  input  logic signed [11:0] y_a_i,
  input  logic signed [11:0] x_b_i,
  input  logic signed [11:0] y_b_i,
  input  logic [9:0]         radius_i,
  input  logic [7:0]         color_i,
  output logic               done_o,
  output logic [23:0]        pixel_data_o,
  output logic               outside_window_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import alcr_pkg::*;

  localparam int Depth = MaxWidth * MaxHeight;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [2:0] {ST_IDLE, ST_LINE, ST_CSTEP, ST_CPLOT, ST_READ, ST_RWAIT} st_e;

  st_e               state_q;
  logic              wide_q;
  logic [6:0]        hw_q, hh_q;
  logic [7:0]        color_q;
  logic              xmaj_q;
  logic signed [11:0] major_q, minor_q, end_q;
  logic signed [1:0] smaj_q, smin_q;
  logic signed [14:0] lmaj_q, lmin_q, err_q;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic signed [11:0] x_q, y_q;
  logic signed [15:0] d_q;
  logic [2:0]        sub_q;
  logic              done_q, out_q;
  logic [23:0]       pix_q;

  frame_req_t        req;
  frame_rsp_t        rsp;
  logic [AddrW-1:0]  addr;
  logic [PixW-1:0]   rdata;

  // config port
  logic wr;
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      REG_WIDE: prdata = {31'd0, wide_q};
      REG_HW:   prdata = {25'd0, hw_q};
      REG_HH:   prdata = {25'd0, hh_q};
      default:  prdata = '0;
    endcase
  end

  // effective window
  logic signed [CoordW-1:0] hw, hh;
  always_comb begin
    hw = (CoordW'(hw_q) > CoordW'(MaxWidth / 2)) ? CoordW'(MaxWidth / 2) : CoordW'(hw_q);
    hh = (CoordW'(hh_q) > CoordW'(MaxHeight / 2)) ? CoordW'(MaxHeight / 2) : CoordW'(hh_q);
  end

  // line step
  logic               ge;
  logic signed [14:0] err_t;
  logic signed [11:0] minor_n, major_n;
  always_comb begin
    ge      = err_q >= lmaj_q;
    err_t   = ge ? err_q - lmaj_q : err_q;
    minor_n = ge ? minor_q + 12'(smin_q) : minor_q;
    major_n = major_q + 12'(smaj_q);
  end

  // circle point of the current octant
  logic signed [CoordW-1:0] dx, dy, a, b;
  always_comb begin
    a  = CoordW'(x_q);
    b  = CoordW'(y_q);
    dx = (sub_q == 3'd1 || sub_q == 3'd2 || sub_q == 3'd5 || sub_q == 3'd6) ? b : a;
    dy = (sub_q == 3'd1 || sub_q == 3'd2 || sub_q == 3'd5 || sub_q == 3'd6) ? a : b;
    if (sub_q == 3'd2 || sub_q == 3'd3 || sub_q == 3'd4 || sub_q == 3'd5) dx = -dx;
    if (sub_q == 3'd4 || sub_q == 3'd5 || sub_q == 3'd6 || sub_q == 3'd7) dy = -dy;
  end

  // point select and locate
  logic signed [CoordW-1:0] px, py, row, col;
  logic in_win;
  always_comb begin
    unique case (state_q)
      ST_LINE: begin
        px = xmaj_q ? CoordW'(major_q) : CoordW'(minor_n);
        py = xmaj_q ? CoordW'(minor_n) : CoordW'(major_q);
      end
      ST_CPLOT: begin
        px = cx_q + dx;
        py = cy_q + dy;
      end
      default: begin
        px = cx_q;
        py = cy_q;
      end
    endcase
    in_win = (px < hw) && (px > -hw) && (py < hh) && (py > -hh);
    row    = hh - py;
    col    = px + hw;
    addr   = AddrW'(row) * AddrW'(MaxWidth) + AddrW'(col);
  end

  logic adv;
  always_comb begin
    req.valid = in_win && (state_q == ST_LINE || state_q == ST_CPLOT || state_q == ST_READ);
    req.rd    = (state_q == ST_READ);
    req.wide  = wide_q;
    req.color = color_q;
    adv       = !in_win || rsp.ready;
  end

  alcr_frame #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight)
  ) u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .addr_i (addr),
    .rsp_o  (rsp),
    .rdata_o(rdata)
  );

  // command decode
  logic signed [12:0] lx, ly;
  logic signed [15:0] d_n;
  always_comb begin
    lx  = (x_a_i > x_b_i) ? 13'(x_a_i) - 13'(x_b_i) : 13'(x_b_i) - 13'(x_a_i);
    ly  = (y_a_i > y_b_i) ? 13'(y_a_i) - 13'(y_b_i) : 13'(y_b_i) - 13'(y_a_i);
    d_n = d_q[15] ? d_q + 16'(x_q) * 16'sd4 + 16'sd6
                  : d_q + (16'(x_q) - 16'(y_q)) * 16'sd4 + 16'sd10;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wide_q  <= 1'b0;
      hw_q    <= 7'd64;
      hh_q    <= 7'd64;
      done_q  <= 1'b0;
      out_q   <= 1'b0;
      pix_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (wr) begin
        unique case (paddr[3:2])
          REG_WIDE: wide_q <= pwdata[0];
          REG_HW:   hw_q   <= pwdata[6:0];
          REG_HH:   hh_q   <= pwdata[6:0];
          default:  ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_i && !busy_o) begin
            color_q <= color_i;
            cx_q    <= CoordW'(x_a_i);
            cy_q    <= CoordW'(y_a_i);
            x_q     <= -12'sd1;
            y_q     <= 12'(radius_i);
            d_q     <= 16'sd3 - 16'(radius_i) * 16'sd2;
            err_q   <= '0;
            xmaj_q  <= lx > ly;
            if (lx > ly) begin
              major_q <= x_a_i;
              minor_q <= y_a_i;
              end_q   <= x_b_i;
              smaj_q  <= (x_a_i > x_b_i) ? -2'sd1 : 2'sd1;
              smin_q  <= (y_a_i > y_b_i) ? -2'sd1 : 2'sd1;
              lmaj_q  <= 15'(lx);
              lmin_q  <= 15'(ly);
            end else begin
              major_q <= y_a_i;
              minor_q <= x_a_i;
              end_q   <= y_b_i;
              smaj_q  <= (y_a_i > y_b_i) ? -2'sd1 : 2'sd1;
              smin_q  <= (x_a_i > x_b_i) ? -2'sd1 : 2'sd1;
              lmaj_q  <= 15'(ly);
              lmin_q  <= 15'(lx);
            end
            pix_q <= '0;
            out_q <= 1'b0;
            case (kind_i)
              KIND_LINE: begin
                if (lx == 13'sd0 && ly == 13'sd0) done_q <= 1'b1;
                else state_q <= ST_LINE;
              end
              KIND_CIRCLE: state_q <= ST_CSTEP;
              KIND_READ:   state_q <= ST_READ;
              default:     done_q  <= 1'b1;
            endcase
          end
        end
        ST_LINE: begin
          if (adv) begin
            minor_q <= minor_n;
            err_q   <= err_t + lmin_q;
            major_q <= major_n;
            if (major_n == end_q) begin
              state_q <= ST_IDLE;
              done_q  <= 1'b1;
            end
          end
        end
        ST_CSTEP: begin
          if (x_q <= y_q) begin
            d_q     <= d_n;
            x_q     <= x_q + 12'sd1;
            if (!d_q[15]) y_q <= y_q - 12'sd1;
            sub_q   <= '0;
            state_q <= ST_CPLOT;
          end else begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        ST_CPLOT: begin
          if (adv) begin
            sub_q <= sub_q + 3'd1;
            if (sub_q == 3'd7) state_q <= ST_CSTEP;
          end
        end
        ST_READ: begin
          if (!in_win) begin
            out_q   <= 1'b1;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (rsp.ready) begin
            state_q <= ST_RWAIT;
          end
        end
        ST_RWAIT: begin
          if (rsp.rvalid) begin
            pix_q   <= rdata;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o           = (state_q != ST_IDLE) || !rsp.ready;
  assign done_o           = done_q;
  assign pixel_data_o     = pix_q;
  assign outside_window_o = out_q;
endmodule

[sim/additive_line_circle_rasterizer_test.sv]
// additive_line_circle_rasterizer_test: self-checking bench for the line and circle rasterizer
// drives command beats and apb register writes, predicts result beats in a local frame copy
// depends on alcr_pkg and additive_line_circle_rasterizer
`timescale 1ns / 1ps
module additive_line_circle_rasterizer_test;
  import alcr_pkg::*;

  localparam int FrameW     = 128;
  localparam int FrameH     = 128;
  localparam int CycleLimit = 40000000;

  typedef struct {
    logic [1:0]         kind;
    logic signed [11:0] xa, ya, xb, yb;
    logic [9:0]         radius;
    logic [7:0]         color;
    bit                 fixed;
    logic [23:0]        fix_pix;
    logic               fix_out;
  } cmd_t;

  typedef struct {
    logic [23:0] pix;
    logic        outside;
  } pixel_beat_t;

  logic clk_i, rst_ni;
  logic start_i, busy_o, done_o, outside_window_o;
  logic [1:0] kind_i;
  logic signed [11:0] x_a_i, y_a_i, x_b_i, y_b_i;
  logic [9:0] radius_i;
  logic [7:0] color_i;
  logic [23:0] pixel_data_o;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  additive_line_circle_rasterizer dut (.*);

  // local copy of the frame store and registers
  logic [23:0] frame_copy [FrameW*FrameH];
  logic        wide_q;
  logic [6:0]  hw_q, hh_q;

  pixel_beat_t pending_pixels [$];
  cmd_t        directed_rows [$];
  int          mismatches;
  int          cycles;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic bit window_index(int x, int y, output int idx);
    int hw, hh;
    hw = (hw_q > FrameW/2) ? FrameW/2 : int'(hw_q);
    hh = (hh_q > FrameH/2) ? FrameH/2 : int'(hh_q);
    idx = 0;
    if (x >= hw || x <= -hw || y >= hh || y <= -hh) return 0;
    idx = (hh - y) * FrameW + (x + hw);
    return 1;
  endfunction

  function automatic void add_point(int x, int y, logic [7:0] color);
    int idx, v;
    logic [23:0] px;
    if (!window_index(x, y, idx)) return;
    px = frame_copy[idx];
    for (int c = 0; c < (wide_q ? 3 : 1); c++) begin
      v = px[8*c +: 8] + color;
      px[8*c +: 8] = (v > 255) ? 8'hff : v[7:0];
    end
    frame_copy[idx] = px;
  endfunction

  function automatic void trace_line(int x1, int y1, int x2, int y2, logic [7:0] color);
    int lx, ly, sx, sy, major, minor, err;
    lx = (x1 > x2) ? x1 - x2 : x2 - x1;
    ly = (y1 > y2) ? y1 - y2 : y2 - y1;
    sx = (x1 > x2) ? -1 : 1;
    sy = (y1 > y2) ? -1 : 1;
    err = 0;
    if (lx > ly) begin
      minor = y1;
      for (major = x1; major != x2; major += sx) begin
        if (err >= lx) begin
          err -= lx;
          minor += sy;
        end
        add_point(major, minor, color);
        err += ly;
      end
    end else begin
      minor = x1;
      for (major = y1; major != y2; major += sy) begin
        if (err >= ly) begin
          err -= ly;
          minor += sx;
        end
        add_point(minor, major, color);
        err += lx;
      end
    end
  endfunction

  function automatic void trace_circle(int cx, int cy, int r, logic [7:0] color);
    int x, y, d;
    x = -1;
    y = r;
    d = 3 - 2 * r;
    while (x <= y) begin
      if (d < 0) begin
        d += 4 * x + 6;
        x++;
      end else begin
        d += 4 * (x - y) + 10;
        x++;
        y--;
      end
      add_point(cx + x, cy + y, color);
      add_point(cx + y, cy + x, color);
      add_point(cx - y, cy + x, color);
      add_point(cx - x, cy + y, color);
      add_point(cx - x, cy - y, color);
      add_point(cx - y, cy - x, color);
      add_point(cx + y, cy - x, color);
      add_point(cx + x, cy - y, color);
    end
  endfunction

  function automatic pixel_beat_t run_command(cmd_t c);
    pixel_beat_t res;
    int idx;
    res.pix = '0;
    res.outside = 1'b0;
    case (c.kind)
      KIND_LINE:   trace_line(c.xa, c.ya, c.xb, c.yb, c.color);
      KIND_CIRCLE: trace_circle(c.xa, c.ya, int'(c.radius), c.color);
      KIND_READ: begin
        if (window_index(c.xa, c.ya, idx)) res.pix = frame_copy[idx];
        else res.outside = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // result beats cannot be held off, so check every done strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected beat", 32'(pixel_data_o), 32'd0);
      end else begin
        pixel_beat_t want;
        want = pending_pixels.pop_front();
        if (pixel_data_o !== want.pix)
          report_mismatch("pixel_data", 32'(pixel_data_o), 32'(want.pix));
        if (outside_window_o !== want.outside)
          report_mismatch("outside_window", 32'(outside_window_o), 32'(want.outside));
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDE: wide_q = val[0];
      REG_HW:   hw_q = val[6:0];
      REG_HH:   hh_q = val[6:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic set_window(logic wide, logic [6:0] hw, logic [6:0] hh);
    drain_and_settle();
    reg_write(REG_WIDE, {31'd0, wide});
    reg_write(REG_HW, {25'd0, hw});
    reg_write(REG_HH, {25'd0, hh});
  endtask

  task automatic issue(cmd_t c);
    pixel_beat_t res;
    if (!quiet && $urandom_range(0, 99) < 31) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while (busy_o);
      repeat ($urandom_range(0, 5)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i <= c.kind;
    x_a_i <= c.xa;
    y_a_i <= c.ya;
    x_b_i <= c.xb;
    y_b_i <= c.yb;
    radius_i <= c.radius;
    color_i <= c.color;
    do @(posedge clk_i); while (busy_o);
    res = run_command(c);
    if (c.fixed) begin
      res.pix = c.fix_pix;
      res.outside = c.fix_out;
    end
    pending_pixels.push_back(res);
  endtask

  task automatic add_row(logic [1:0] k, int xa, int ya, int xb, int yb, int r, int col,
                         bit fixed = 0, logic [23:0] pix = 0, logic out = 0);
    cmd_t c;
    c.kind = k;
    c.xa = 12'(xa);
    c.ya = 12'(ya);
    c.xb = 12'(xb);
    c.yb = 12'(yb);
    c.radius = 10'(r);
    c.color = 8'(col);
    c.fixed = fixed;
    c.fix_pix = pix;
    c.fix_out = out;
    directed_rows.push_back(c);
  endtask

  function automatic logic signed [11:0] any_coord(int span);
    if ($urandom_range(0, 9) == 0) return 12'($urandom);
    return 12'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.fixed = 0;
    c.fix_pix = '0;
    c.fix_out = 1'b0;
    c.kind = (sel < 30) ? KIND_LINE : (sel < 55) ? KIND_CIRCLE :
             (sel < 92) ? KIND_READ : KIND_UNUSED;
    c.xa = (c.kind == KIND_READ) ? any_coord(66) : any_coord(80);
    c.ya = (c.kind == KIND_READ) ? any_coord(66) : any_coord(80);
    c.xb = any_coord(80);
    c.yb = any_coord(80);
    if ($urandom_range(0, 24) == 0) c.radius = 10'($urandom_range(512, 1023));
    else c.radius = 10'($urandom_range(0, 90));
    c.color = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
    return c;
  endfunction

  initial begin
    logic [6:0] whw [9] = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd17, 7'd64, 7'd33, 7'd2, 7'd64};
    logic [6:0] whh [9] = '{7'd64, 7'd1, 7'd127, 7'd5, 7'd40, 7'd0, 7'd64, 7'd63, 7'd64};
    quiet = 0;
    wide_q = 1'b0;
    hw_q = 7'd64;
    hh_q = 7'd64;
    foreach (frame_copy[i]) frame_copy[i] = '0;
    start_i = 1'b0;
    kind_i = '0;
    x_a_i = '0;
    y_a_i = '0;
    x_b_i = '0;
    y_b_i = '0;
    radius_i = '0;
    color_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    set_window(1'b0, 7'd64, 7'd64);
    add_row(KIND_READ, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(KIND_READ, 63, -63, 0, 0, 0, 0, 1, 0, 0);
    add_row(KIND_READ, 64, 0, 0, 0, 0, 0, 1, 0, 1);
    add_row(KIND_READ, 0, -64, 0, 0, 0, 0, 1, 0, 1);
    add_row(KIND_READ, -2048, 2047, 0, 0, 0, 0, 1, 0, 1);
    add_row(KIND_UNUSED, -1, -1, -1, -1, 1023, 255, 1, 0, 0);
    add_row(KIND_LINE, 0, 0, 5, 3, 0, 255, 1, 0, 0);
    add_row(KIND_READ, 0, 0, 0, 0, 0, 0);
    add_row(KIND_READ, 5, 3, 0, 0, 0, 0);
    add_row(KIND_LINE, 1, 1, 1, 1, 0, 200, 1, 0, 0);
    add_row(KIND_READ, 1, 1, 0, 0, 0, 0);
    add_row(KIND_LINE, -2048, -2048, 2047, 2047, 0, 200, 1, 0, 0);
    add_row(KIND_READ, 10, 10, 0, 0, 0, 0);
    add_row(KIND_LINE, 3, -20, -2, 40, 0, 0, 1, 0, 0);
    add_row(KIND_LINE, 3, -20, -2, 40, 0, 77, 1, 0, 0);
    add_row(KIND_READ, 0, 14, 0, 0, 0, 0);
    add_row(KIND_CIRCLE, 0, 0, 0, 0, 0, 100, 1, 0, 0);
    add_row(KIND_READ, 0, 0, 0, 0, 0, 0);
    add_row(KIND_CIRCLE, 0, 0, 0, 0, 30, 255, 1, 0, 0);
    add_row(KIND_READ, 0, 30, 0, 0, 0, 0);
    add_row(KIND_CIRCLE, -2048, 2047, 0, 0, 1023, 1, 1, 0, 0);
    add_row(KIND_CIRCLE, 2047, -2048, 0, 0, 1023, 9, 1, 0, 0);
    add_row(KIND_READ, -63, 63, 0, 0, 0, 0);
    foreach (directed_rows[i]) issue(directed_rows[i]);
    start_i <= 1'b0;

    for (int ph = 0; ph < 9; ph++) begin
      set_window(ph[0], whw[ph], whh[ph]);
      quiet = (ph == 4);
      for (int n = 0; n < 60; n++) issue(random_command());
      start_i <= 1'b0;
    end

    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[files.f]
src/alcr_pkg.sv
src/alcr_frame.sv
src/additive_line_circle_rasterizer.sv
sim/additive_line_circle_rasterizer_test.sv
